/* rtl/core/tdu_pkg.sv */
// Shared types and codes for the toric distance unit.
// No dependencies; every other file but the two channel interfaces refers to it by scoped names.

package tdu_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METRIC = 1'b0,
    CFG_WRAP   = 1'b1
  } cfg_idx_e;

  // Distance metric codes; the fourth code yields a zero distance
  typedef enum logic [CFG_DATA_W-1:0] {
    METRIC_EUCLID    = 2'd0,
    METRIC_MANHATTAN = 2'd1,
    METRIC_MAXIMUM   = 2'd2
  } metric_e;

  // Control that travels with each transaction down the pipeline
  typedef struct packed {
    logic    valid;
    metric_e metric;
  } ctl_t;

endpackage

/* rtl/core/tdu_pair_if.sv */
// Input channel: one point pair per transaction, valid/ready handshake.
// Depends on nothing; width follows the coordinate width parameter.

interface tdu_pair_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] second_x;
  logic [COORD_BITS-1:0] second_y;

  modport source (output valid, output first_x, output first_y,
                  output second_x, output second_y, input ready);
  modport sink   (input valid, input first_x, input first_y,
                  input second_x, input second_y, output ready);
endinterface

/* rtl/core/tdu_dist_if.sv */
// Output channel: one distance per transaction, valid/ready handshake.
// Depends on nothing; width is one bit above the coordinate width.

interface tdu_dist_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [COORD_BITS:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

/* rtl/core/tdu_diff.sv */
// First pipeline stage: absolute coordinate differences with optional torus wrap.
// Depends on tdu_pkg for the control struct.

module tdu_diff #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  tdu_pkg::ctl_t         ctl_i,
  input  logic                  wrap_i,
  input  logic [COORD_BITS-1:0] first_x_i,
  input  logic [COORD_BITS-1:0] first_y_i,
  input  logic [COORD_BITS-1:0] second_x_i,
  input  logic [COORD_BITS-1:0] second_y_i,
  output tdu_pkg::ctl_t         ctl_o,
  output logic [COORD_BITS-1:0] dx_o,
  output logic [COORD_BITS-1:0] dy_o
);

  tdu_pkg::ctl_t         ctl_q;
  logic [COORD_BITS-1:0] dx_d, dx_q;
  logic [COORD_BITS-1:0] dy_d, dy_q;

  // |a - b|, then min(d, one - d) when wrapping; a tie keeps d
  function automatic logic [COORD_BITS-1:0] fold_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b,
    input logic                  wrap
  );
    logic [COORD_BITS-1:0] d;
    logic [COORD_BITS:0]   other;
    d     = (a > b) ? (a - b) : (b - a);
    other = {1'b1, {COORD_BITS{1'b0}}} - {1'b0, d};
    if (wrap && (other < {1'b0, d})) begin
      d = other[COORD_BITS-1:0];
    end
    return d;
  endfunction

  always_comb begin
    dx_d = fold_diff(first_x_i, second_x_i, wrap_i);
    dy_d = fold_diff(first_y_i, second_y_i, wrap_i);
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign ctl_o = ctl_q;
  assign dx_o  = dx_q;
  assign dy_o  = dy_q;

endmodule

/* rtl/core/tdu_square.sv */
// Second and third pipeline stages: squares of the differences, then their sum.
// Also forms the Manhattan / maximum result. Depends on tdu_pkg.

module tdu_square #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  tdu_pkg::ctl_t           ctl_i,
  input  logic [COORD_BITS-1:0]   dx_i,
  input  logic [COORD_BITS-1:0]   dy_i,
  output tdu_pkg::ctl_t           ctl_o,
  output logic [2*COORD_BITS:0]   sum_o,
  output logic [COORD_BITS:0]     alt_o
);

  tdu_pkg::ctl_t           prod_ctl_q, sum_ctl_q;
  logic [2*COORD_BITS-1:0] sq_x_d, sq_x_q;
  logic [2*COORD_BITS-1:0] sq_y_d, sq_y_q;
  logic [COORD_BITS:0]     alt_d, prod_alt_q, sum_alt_q;
  logic [2*COORD_BITS:0]   sum_d, sum_q;

  // Products and the non-Euclidean metrics
  always_comb begin
    sq_x_d = (2*COORD_BITS)'(dx_i) * (2*COORD_BITS)'(dx_i);
    sq_y_d = (2*COORD_BITS)'(dy_i) * (2*COORD_BITS)'(dy_i);
    case (ctl_i.metric)
      tdu_pkg::METRIC_MANHATTAN: alt_d = {1'b0, dx_i} + {1'b0, dy_i};
      tdu_pkg::METRIC_MAXIMUM:   alt_d = (dx_i > dy_i) ? {1'b0, dx_i} : {1'b0, dy_i};
      default:                   alt_d = '0;
    endcase
  end

  // Sum of squares, one bit wider
  assign sum_d = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctl_q <= '0;
      sum_ctl_q  <= '0;
    end else if (en_i) begin
      prod_ctl_q <= ctl_i;
      sum_ctl_q  <= prod_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q     <= sq_x_d;
      sq_y_q     <= sq_y_d;
      prod_alt_q <= alt_d;
      sum_q      <= sum_d;
      sum_alt_q  <= prod_alt_q;
    end
  end

  assign ctl_o = sum_ctl_q;
  assign sum_o = sum_q;
  assign alt_o = sum_alt_q;

endmodule

/* rtl/core/tdu_sqrt_stage.sv */
// One stage of the pipelined integer square root: up to two root bits per stage,
// restoring digit-by-digit method. Depends on tdu_pkg for the control struct.

module tdu_sqrt_stage #(
  parameter int unsigned ROOT_W = 17,
  parameter int unsigned NSTEP  = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  tdu_pkg::ctl_t         ctl_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [ROOT_W+1:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [ROOT_W-1:0]     alt_i,
  output tdu_pkg::ctl_t         ctl_o,
  output logic [2*ROOT_W-1:0]   rad_o,
  output logic [ROOT_W+1:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [ROOT_W-1:0]     alt_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  tdu_pkg::ctl_t       ctl_q;
  logic [RAD_W-1:0]    rad_d, rad_q;
  logic [REM_W-1:0]    rem_d, rem_q;
  logic [ROOT_W-1:0]   root_d, root_q;
  logic [ROOT_W-1:0]   alt_q;

  // Bring down a bit pair, try subtracting 4*root + 1
  always_comb begin
    logic [REM_W+1:0] rem_ext;
    logic [REM_W+1:0] trial;
    rad_d   = rad_i;
    rem_d   = rem_i;
    root_d  = root_i;
    rem_ext = '0;
    trial   = '0;
    for (int s = 0; s < NSTEP; s++) begin
      rem_ext = {rem_d, rad_d[RAD_W-1 -: 2]};
      trial   = {2'b00, root_d, 2'b01};
      rad_d   = rad_d << 2;
      if (rem_ext >= trial) begin
        rem_ext = rem_ext - trial;
        root_d  = {root_d[ROOT_W-2:0], 1'b1};
      end else begin
        root_d  = {root_d[ROOT_W-2:0], 1'b0};
      end
      rem_d = rem_ext[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      alt_q  <= alt_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign alt_o  = alt_q;

endmodule

/* rtl/core/toric_distance_unit.sv */
// Toric distance unit: takes one pair of points per transaction and returns their
// Euclidean (floored), Manhattan or maximum distance, optionally wrapped on the
// unit torus. It accepts a new pair every clock cycle while the output is not
// stalled; each result passes the difference, product and sum stages, then the
// square-root pipeline, which resolves up to two root bits per stage, and the
// output register. The whole pipeline advances whenever the output register is
// empty or being drained, so backpressure freezes it without losing or repeating
// a transaction.
// Configuration writes are meant for idle periods only.

module toric_distance_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tdu_pair_if.sink                           pair_i,
  tdu_dist_if.source                         dist_o,
  input  logic                               cfg_we_i,
  input  logic [tdu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tdu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned NSQ    = (ROOT_W + 1) / 2;

  tdu_pkg::metric_e      metric_q;
  logic                  wrap_q;
  logic                  en;
  tdu_pkg::ctl_t         in_ctl;
  tdu_pkg::ctl_t         diff_ctl;
  logic [COORD_BITS-1:0] dx, dy;
  tdu_pkg::ctl_t         sum_ctl;
  logic [2*COORD_BITS:0] sum;
  logic [COORD_BITS:0]   alt;

  tdu_pkg::ctl_t         sq_ctl  [NSQ+1];
  logic [RAD_W-1:0]      sq_rad  [NSQ+1];
  logic [REM_W-1:0]      sq_rem  [NSQ+1];
  logic [ROOT_W-1:0]     sq_root [NSQ+1];
  logic [ROOT_W-1:0]     sq_alt  [NSQ+1];

  tdu_pkg::ctl_t         out_ctl_q;
  logic [COORD_BITS:0]   dist_d, dist_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= tdu_pkg::METRIC_EUCLID;
      wrap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (tdu_pkg::cfg_idx_e'(cfg_idx_i))
        tdu_pkg::CFG_METRIC: metric_q <= tdu_pkg::metric_e'(cfg_data_i);
        tdu_pkg::CFG_WRAP:   wrap_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: output register empty or being taken
  assign en           = !out_ctl_q.valid || dist_o.ready;
  assign pair_i.ready = en;

  assign in_ctl.valid  = pair_i.valid;
  assign in_ctl.metric = metric_q;

  tdu_diff #(
    .COORD_BITS (COORD_BITS)
  ) u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (in_ctl),
    .wrap_i     (wrap_q),
    .first_x_i  (pair_i.first_x),
    .first_y_i  (pair_i.first_y),
    .second_x_i (pair_i.second_x),
    .second_y_i (pair_i.second_y),
    .ctl_o      (diff_ctl),
    .dx_o       (dx),
    .dy_o       (dy)
  );

  tdu_square #(
    .COORD_BITS (COORD_BITS)
  ) u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (diff_ctl),
    .dx_i   (dx),
    .dy_i   (dy),
    .ctl_o  (sum_ctl),
    .sum_o  (sum),
    .alt_o  (alt)
  );

  // Square-root pipeline entry
  assign sq_ctl[0]  = sum_ctl;
  assign sq_rad[0]  = {1'b0, sum};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_alt[0]  = alt;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    tdu_sqrt_stage #(
      .ROOT_W (ROOT_W),
      .NSTEP  (((ROOT_W - 2 * k) >= 2) ? 2 : 1)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .alt_i  (sq_alt[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .alt_o  (sq_alt[k+1])
    );
  end

  // Metric select into the output register
  assign dist_d = (sq_ctl[NSQ].metric == tdu_pkg::METRIC_EUCLID) ? sq_root[NSQ]
                                                                 : sq_alt[NSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else if (en) begin
      out_ctl_q <= sq_ctl[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o.valid    = out_ctl_q.valid;
  assign dist_o.distance = dist_q;

`ifndef ASSERT_OFF
  // Finished root leaves a remainder no larger than twice the root
  a_sqrt_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_ctl[NSQ].valid |-> ({1'b0, sq_rem[NSQ]} <= {2'b00, sq_root[NSQ], 1'b0}))
    else $error("square root remainder out of range");

  // Maximum metric never reaches the top bit
  a_max_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ctl_q.valid && (out_ctl_q.metric == tdu_pkg::METRIC_MAXIMUM))
      |-> (dist_q[COORD_BITS] == 1'b0))
    else $error("maximum distance exceeds coordinate range");

  // Unused metric code returns zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ctl_q.valid && (out_ctl_q.metric != tdu_pkg::METRIC_EUCLID)
      && (out_ctl_q.metric != tdu_pkg::METRIC_MANHATTAN)
      && (out_ctl_q.metric != tdu_pkg::METRIC_MAXIMUM))
      |-> (dist_q == '0))
    else $error("unused metric code gave a nonzero distance");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the toric distance unit: random and directed point pairs,
// every metric with and without torus wrap. Depends on tdu_pkg, the two channel
// interfaces and the unit itself from the RTL tree.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIST_W    = COORD_W + 1;
  localparam int unsigned LATENCY   = 13;
  localparam int unsigned DRAIN_GAP = LATENCY + 4;
  localparam int unsigned WDOG_MAX  = 4000;
  localparam int unsigned N_PHASES  = 16;
  localparam int unsigned PER_PHASE = 106;

  // Spare metric code with no enum member; the unit answers zero
  localparam logic [tdu_pkg::CFG_DATA_W-1:0] METRIC_UNUSED = 2'd3;
  localparam logic [tdu_pkg::CFG_DATA_W-1:0] METRIC_CODES [4] =
    '{tdu_pkg::METRIC_EUCLID, tdu_pkg::METRIC_MANHATTAN, tdu_pkg::METRIC_MAXIMUM,
      METRIC_UNUSED};

  // One unit in Q0.16
  localparam logic [COORD_W:0] COORD_ONE = 17'h10000;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
  } pair_t;

  // How the second point of a random pair relates to the first, per axis
  typedef enum logic [1:0] {
    GAP_UNIFORM,
    GAP_CLOSE,
    GAP_HALF,
    GAP_EDGE
  } gap_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                           cfg_we;
  logic [tdu_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tdu_pkg::CFG_DATA_W-1:0] cfg_data;

  tdu_pair_if #(.COORD_BITS(COORD_W)) pair_if ();
  tdu_dist_if #(.COORD_BITS(COORD_W)) dist_if ();

  toric_distance_unit #(.COORD_BITS(COORD_W)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_i     (pair_if),
    .dist_o     (dist_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the unit's registers, as last written
  logic [tdu_pkg::CFG_DATA_W-1:0] metric_cfg;
  logic                           wrap_cfg;

  pair_t             pending_pairs [$];
  logic [DIST_W-1:0] expected_dist [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pairs_queued;
  int unsigned pairs_sent;
  int unsigned dists_seen;
  int unsigned settings_run;
  int unsigned error_count;
  int unsigned stall_cycles;

  // Floor square root, one root bit per step from the top
  function automatic logic [DIST_W-1:0] floor_sqrt(input logic [2*DIST_W-1:0] v);
    logic [2*DIST_W-1:0] root;
    logic [2*DIST_W-1:0] trial;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  // Shorter way around the torus; an exact half keeps the direct gap
  function automatic logic [COORD_W-1:0] fold_torus(input logic [COORD_W-1:0] d);
    logic [COORD_W:0] rest;
    rest = COORD_ONE - {1'b0, d};
    if (rest < {1'b0, d}) return rest[COORD_W-1:0];
    return d;
  endfunction

  function automatic logic [DIST_W-1:0] calc_distance(
    input pair_t                          p,
    input logic [tdu_pkg::CFG_DATA_W-1:0] metric,
    input logic                           wrap
  );
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [2*DIST_W-1:0] sum_sq;
    dx = (p.first_x > p.second_x) ? p.first_x - p.second_x : p.second_x - p.first_x;
    dy = (p.first_y > p.second_y) ? p.first_y - p.second_y : p.second_y - p.first_y;
    if (wrap) begin
      dx = fold_torus(dx);
      dy = fold_torus(dy);
    end
    case (metric)
      tdu_pkg::METRIC_EUCLID: begin
        sum_sq = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
        return floor_sqrt(sum_sq);
      end
      tdu_pkg::METRIC_MANHATTAN: return DIST_W'(dx) + DIST_W'(dy);
      tdu_pkg::METRIC_MAXIMUM:   return (dx > dy) ? DIST_W'(dx) : DIST_W'(dy);
      default:                   return '0;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] edge_coord();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      default: return 16'h7fff;
    endcase
  endfunction

  // Second coordinate on one axis, shaped to hit wrap boundaries and tiny gaps
  function automatic logic [COORD_W-1:0] partner_coord(input logic [COORD_W-1:0] base,
                                                       input gap_shape_e shape);
    case (shape)
      GAP_CLOSE: return base + 16'($urandom_range(16)) - 16'd8;
      GAP_HALF:  return base + 16'h8000 + 16'($urandom_range(6)) - 16'd3;
      GAP_EDGE:  return edge_coord();
      default:   return 16'($urandom);
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t      p;
    gap_shape_e sx;
    gap_shape_e sy;
    sx = gap_shape_e'($urandom_range(3));
    sy = gap_shape_e'($urandom_range(3));
    p.first_x  = (sx == GAP_EDGE) ? edge_coord() : 16'($urandom);
    p.first_y  = (sy == GAP_EDGE) ? edge_coord() : 16'($urandom);
    p.second_x = partner_coord(p.first_x, sx);
    p.second_y = partner_coord(p.first_y, sy);
    return p;
  endfunction

  task automatic write_reg(input tdu_pkg::cfg_idx_e idx,
                           input logic [tdu_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Both registers; only bit 0 of the wrap word counts
  task automatic set_config(input logic [tdu_pkg::CFG_DATA_W-1:0] metric,
                            input logic [tdu_pkg::CFG_DATA_W-1:0] wrap_word);
    write_reg(tdu_pkg::CFG_METRIC, metric);
    write_reg(tdu_pkg::CFG_WRAP, wrap_word);
    metric_cfg = metric;
    wrap_cfg   = wrap_word[0];
    settings_run++;
  endtask

  task automatic queue_pair(input pair_t p);
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  // Every queued pair answered, then a pipeline's worth of quiet
  task automatic wait_idle();
    while (dists_seen < pairs_queued) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Zero gaps, full-scale gaps both ways, exact half gap, just past and just short of half
  task automatic queue_directed();
    queue_pair('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    queue_pair('{16'h0000, 16'h0000, 16'hffff, 16'hffff});
    queue_pair('{16'hffff, 16'hffff, 16'h0000, 16'h0000});
    queue_pair('{16'h0000, 16'h8000, 16'h8000, 16'h0000});
    queue_pair('{16'h0000, 16'h0000, 16'h8001, 16'h7fff});
    queue_pair('{16'hffff, 16'h0000, 16'h0000, 16'hffff});
  endtask

  // Pair driver: holds valid until the transaction is taken
  always @(posedge clk_i or negedge rst_ni) begin : drive_pairs
    pair_t cur;
    pair_t nxt;
    logic  nxt_valid;
    if (!rst_ni) begin
      pair_if.valid <= 1'b0;
    end else begin
      cur       = {pair_if.first_x, pair_if.first_y, pair_if.second_x, pair_if.second_y};
      nxt       = cur;
      nxt_valid = pair_if.valid;
      if (pair_if.valid && pair_if.ready) begin
        expected_dist.push_back(calc_distance(cur, metric_cfg, wrap_cfg));
        pairs_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_pairs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt       = pending_pairs.pop_front();
        nxt_valid = 1'b1;
      end
      pair_if.valid    <= nxt_valid;
      pair_if.first_x  <= nxt.first_x;
      pair_if.first_y  <= nxt.first_y;
      pair_if.second_x <= nxt.second_x;
      pair_if.second_y <= nxt.second_y;
    end
  end

  // Distance monitor and random backpressure
  always @(posedge clk_i or negedge rst_ni) begin : check_dist
    logic [DIST_W-1:0] want;
    if (!rst_ni) begin
      dist_if.ready <= 1'b0;
    end else begin
      if (dist_if.valid && dist_if.ready) begin
        dists_seen++;
        if (expected_dist.size() == 0) begin
          $display("%0t: distance %0d arrived with no pair outstanding",
                   $time, dist_if.distance);
          error_count++;
        end else begin
          want = expected_dist.pop_front();
          if (dist_if.distance !== want) begin
            $display("%0t: distance mismatch: expected %0d, actual %0d",
                     $time, want, dist_if.distance);
            error_count++;
          end
        end
      end
      dist_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pair_if.valid && pair_if.ready) || (dist_if.valid && dist_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WDOG_MAX) begin
        $display("%0t: no transaction for %0d cycles", $time, WDOG_MAX);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = tdu_pkg::CFG_METRIC;
    cfg_data         = '0;
    pair_if.valid    = 1'b0;
    pair_if.first_x  = '0;
    pair_if.first_y  = '0;
    pair_if.second_x = '0;
    pair_if.second_y = '0;
    dist_if.ready    = 1'b0;
    metric_cfg       = tdu_pkg::METRIC_EUCLID;
    wrap_cfg         = 1'b0;
    send_idle_pct    = 25;
    recv_idle_pct    = 85;
    pairs_queued     = 0;
    pairs_sent       = 0;
    dists_seen       = 0;
    settings_run     = 1;
    error_count      = 0;
    stall_cycles     = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults first, then each metric with odd wrap words
    queue_directed();
    wait_idle();
    set_config(tdu_pkg::METRIC_MANHATTAN, 2'b11);
    queue_directed();
    wait_idle();
    set_config(tdu_pkg::METRIC_MAXIMUM, 2'b10);
    queue_directed();
    wait_idle();
    set_config(METRIC_UNUSED, 2'b01);
    queue_directed();
    wait_idle();

    // Random phases sweep metric and wrap; idling pattern shifts by thirds
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 6) begin
        send_idle_pct = 25;
        recv_idle_pct = 85;
      end else if (ph < 11) begin
        send_idle_pct = 85;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(METRIC_CODES[ph % 4], {1'($urandom_range(1)), 1'((ph / 4) % 2)});
      for (int unsigned k = 0; k < PER_PHASE; k++) queue_pair(random_pair());
      wait_idle();
    end

    // Leftover expectations count as failures
    if (expected_dist.size() != 0) begin
      $display("%0t: %0d expected distances never arrived", $time, expected_dist.size());
      error_count++;
    end

    $display("Sent %0d point pairs under %0d register settings, checked %0d distances,",
             pairs_sent, settings_run, dists_seen);
    $display("all four metric codes with and without torus wrap; %0d errors", error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tdu_pkg.sv
rtl/core/tdu_pair_if.sv
rtl/core/tdu_dist_if.sv
rtl/core/tdu_diff.sv
rtl/core/tdu_square.sv
rtl/core/tdu_sqrt_stage.sv
rtl/core/toric_distance_unit.sv
bench/tb_top.sv
